FILE: rtl/etp_pkg.sv
// Package for the elimination tree parent builder.
// Field widths, item kind codes and shared types. No dependencies.
package etp_pkg;

  localparam int unsigned IDX_W  = 10;  // row, column and node index
  localparam int unsigned PAR_W  = 11;  // parent code, also the row count
  localparam int unsigned SIZE_W = 11;  // union-find set size, saturating
  localparam int unsigned KIND_W = 2;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [PAR_W-1:0]  par_t;
  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_START = 2'd0;
  localparam kind_t KIND_COL   = 2'd1;
  localparam kind_t KIND_READ  = 2'd2;

  localparam par_t  ROW_COUNT_RESET = 11'd1024;
  localparam size_t SIZE_MAX        = 11'h7FF;

endpackage

FILE: rtl/etp_if.sv
// Valid/ready channel interfaces for the elimination tree parent builder.
// Depends on etp_pkg.
interface etp_in_if import etp_pkg::*; ();
  logic  valid;
  logic  ready;
  kind_t kind;
  idx_t  index;
  modport source (output valid, output kind, output index, input ready);
  modport sink   (input valid, input kind, input index, output ready);
endinterface

interface etp_out_if import etp_pkg::*; ();
  logic valid;
  logic ready;
  idx_t node;
  par_t parent_node;
  logic is_root;
  modport source (output valid, output node, output parent_node, output is_root, input ready);
  modport sink   (input valid, input node, input parent_node, input is_root, output ready);
endinterface

interface etp_cfg_if import etp_pkg::*; ();
  logic valid;
  logic ready;
  par_t row_count;
  modport source (output valid, output row_count, input ready);
  modport sink   (input valid, input row_count, output ready);
endinterface

FILE: rtl/etp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read data holds while the read enable is low. No dependencies.
module etp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/elimination_tree_parents.sv
// Elimination forest builder over a streamed symmetric sparsity pattern.
// Depends on etp_pkg, the channel interfaces in etp_if and etp_ram.
//
// Rows are opened with a start item and followed by their column entries;
// a read item returns a node's parent and root flag on the output channel.
// The block handles one item at a time and drops ready while it works. A
// start passes through dispatch only; a read through dispatch and the output
// state, where it waits on the output channel. A column entry below the
// open row goes through dispatch, a find walk to the set representative,
// any path-compression steps, the root and parent lookups, and two size
// states when two distinct sets are merged. Both walks are bounded by the
// union-find depth, about log2 of the set size; the single read port of the
// link memory lets each walk use one link per cycle. The four tables are not
// cleared after reset: every entry is written by the start item of its row.
// Configuration writes are taken at any time and must only be issued while
// the block is idle.
module elimination_tree_parents import etp_pkg::*; #(
  parameter int unsigned MAX_ROWS = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  etp_in_if.sink    in_i,
  etp_out_if.source out_o,
  etp_cfg_if.sink   cfg_i
);

  // Only indexes below both bounds are ever stored.
  localparam int unsigned DEPTH = (MAX_ROWS < (1 << IDX_W)) ? MAX_ROWS : (1 << IDX_W);
  localparam int unsigned AW    = $clog2(DEPTH);

  typedef logic [AW-1:0] addr_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_FIND,
    ST_COMP,
    ST_ROOT,
    ST_PARENT,
    ST_SIZE_A,
    ST_SIZE_B,
    ST_RD_OUT
  } state_e;

  state_e state_q, state_d;

  par_t  row_count_q;
  kind_t kind_q;
  idx_t  idx_q;
  addr_t x_q, x_d, r_q, r_d, root_q, root_d;
  size_t size_a_q, size_a_d;
  idx_t  cur_row_q, cur_row_d;
  addr_t cur_set_q, cur_set_d;
  logic  row_open_q, row_open_d;
  logic  oob_q, oob_d;
  logic  out_valid_q, out_valid_d;
  idx_t  out_node_q, out_node_d;
  par_t  out_par_q, out_par_d;
  logic  out_root_q, out_root_d;

  // RAM ports
  logic  tp_we, tp_re, sl_we, sl_re, ss_we, ss_re, sr_we, sr_re;
  addr_t tp_waddr, tp_raddr, sl_waddr, sl_raddr, ss_waddr, ss_raddr, sr_waddr, sr_raddr;
  par_t  tp_wdata, tp_rdata;
  addr_t sl_wdata, sl_rdata;
  size_t ss_wdata, ss_rdata;
  addr_t sr_wdata, sr_rdata;

  logic              idx_in_range;
  addr_t             idx_clip;
  logic [SIZE_W:0]   size_sum;
  size_t             size_sat;
  par_t              rd_parent;

  assign idx_in_range = int'(idx_q) < MAX_ROWS;
  assign idx_clip     = idx_in_range ? idx_q[AW-1:0] : '0;
  assign size_sum     = {1'b0, size_a_q} + {1'b0, ss_rdata};
  assign size_sat     = size_sum[SIZE_W] ? SIZE_MAX : size_sum[SIZE_W-1:0];
  assign rd_parent    = oob_q ? row_count_q : tp_rdata;

  assign in_i.ready        = (state_q == ST_IDLE);
  assign cfg_i.ready       = 1'b1;
  assign out_o.valid       = out_valid_q;
  assign out_o.node        = out_node_q;
  assign out_o.parent_node = out_par_q;
  assign out_o.is_root     = out_root_q;

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    r_d         = r_q;
    root_d      = root_q;
    size_a_d    = size_a_q;
    cur_row_d   = cur_row_q;
    cur_set_d   = cur_set_q;
    row_open_d  = row_open_q;
    oob_d       = oob_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_node_d  = out_node_q;
    out_par_d   = out_par_q;
    out_root_d  = out_root_q;

    tp_we = 1'b0; tp_waddr = '0; tp_wdata = '0; tp_re = 1'b0; tp_raddr = '0;
    sl_we = 1'b0; sl_waddr = '0; sl_wdata = '0; sl_re = 1'b0; sl_raddr = '0;
    ss_we = 1'b0; ss_waddr = '0; ss_wdata = '0; ss_re = 1'b0; ss_raddr = '0;
    sr_we = 1'b0; sr_waddr = '0; sr_wdata = '0; sr_re = 1'b0; sr_raddr = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        state_d = ST_IDLE;
        case (kind_q)
          KIND_START: begin
            if ({1'b0, idx_q} < row_count_q && idx_in_range) begin
              tp_we = 1'b1; tp_waddr = idx_clip; tp_wdata = row_count_q;
              sl_we = 1'b1; sl_waddr = idx_clip; sl_wdata = idx_clip;
              ss_we = 1'b1; ss_waddr = idx_clip; ss_wdata = SIZE_W'(1);
              sr_we = 1'b1; sr_waddr = idx_clip; sr_wdata = idx_clip;
              cur_row_d  = idx_q;
              cur_set_d  = idx_clip;
              row_open_d = 1'b1;
            end
          end
          KIND_COL: begin
            if (row_open_q && idx_q < cur_row_q) begin
              x_d      = idx_clip;
              r_d      = idx_clip;
              sl_re    = 1'b1;
              sl_raddr = idx_clip;
              state_d  = ST_FIND;
            end
          end
          KIND_READ: begin
            oob_d = !idx_in_range;
            tp_re = 1'b1;
            tp_raddr = idx_clip;
            state_d = ST_RD_OUT;
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end

      // sl_rdata holds link[r_q]
      ST_FIND: begin
        if (sl_rdata == r_q) begin
          if (x_q == r_q) begin
            sr_re = 1'b1; sr_raddr = r_q;
            state_d = ST_ROOT;
          end else begin
            sl_re = 1'b1; sl_raddr = x_q;
            state_d = ST_COMP;
          end
        end else begin
          r_d = sl_rdata;
          sl_re = 1'b1; sl_raddr = sl_rdata;
        end
      end

      // sl_rdata holds link[x_q]; point x at the representative, move on
      ST_COMP: begin
        sl_we = 1'b1; sl_waddr = x_q; sl_wdata = r_q;
        x_d = sl_rdata;
        if (sl_rdata == r_q) begin
          sr_re = 1'b1; sr_raddr = r_q;
          state_d = ST_ROOT;
        end else begin
          sl_re = 1'b1; sl_raddr = sl_rdata;
        end
      end

      ST_ROOT: begin
        root_d = sr_rdata;
        tp_re = 1'b1; tp_raddr = sr_rdata;
        state_d = ST_PARENT;
      end

      ST_PARENT: begin
        state_d = ST_IDLE;
        if (tp_rdata == row_count_q && IDX_W'(root_q) != cur_row_q) begin
          tp_we = 1'b1; tp_waddr = root_q; tp_wdata = PAR_W'(cur_row_q);
          if (cur_set_q == r_q) begin
            sr_we = 1'b1; sr_waddr = cur_set_q; sr_wdata = cur_row_q[AW-1:0];
          end else begin
            ss_re = 1'b1; ss_raddr = cur_set_q;
            state_d = ST_SIZE_A;
          end
        end
      end

      ST_SIZE_A: begin
        size_a_d = ss_rdata;
        ss_re = 1'b1; ss_raddr = r_q;
        state_d = ST_SIZE_B;
      end

      // union by size; ties keep the current row's set as the larger one
      ST_SIZE_B: begin
        if (size_a_q < ss_rdata) begin
          sl_we = 1'b1; sl_waddr = cur_set_q; sl_wdata = r_q;
          ss_we = 1'b1; ss_waddr = r_q;       ss_wdata = size_sat;
          sr_we = 1'b1; sr_waddr = r_q;       sr_wdata = cur_row_q[AW-1:0];
          cur_set_d = r_q;
        end else begin
          sl_we = 1'b1; sl_waddr = r_q;       sl_wdata = cur_set_q;
          ss_we = 1'b1; ss_waddr = cur_set_q; ss_wdata = size_sat;
          sr_we = 1'b1; sr_waddr = cur_set_q; sr_wdata = cur_row_q[AW-1:0];
        end
        state_d = ST_IDLE;
      end

      ST_RD_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_node_d  = idx_q;
          out_par_d   = rd_parent;
          out_root_d  = (rd_parent == row_count_q);
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_count_q <= ROW_COUNT_RESET;
      cur_row_q   <= '0;
      cur_set_q   <= '0;
      row_open_q  <= 1'b0;
      out_valid_q <= 1'b0;
      kind_q      <= KIND_START;
      idx_q       <= '0;
      x_q         <= '0;
      r_q         <= '0;
      root_q      <= '0;
      size_a_q    <= '0;
      oob_q       <= 1'b0;
      out_node_q  <= '0;
      out_par_q   <= '0;
      out_root_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_row_q   <= cur_row_d;
      cur_set_q   <= cur_set_d;
      row_open_q  <= row_open_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        row_count_q <= cfg_i.row_count;
      end
      if (in_i.valid && state_q == ST_IDLE) begin
        kind_q <= in_i.kind;
        idx_q  <= in_i.index;
      end
      x_q        <= x_d;
      r_q        <= r_d;
      root_q     <= root_d;
      size_a_q   <= size_a_d;
      oob_q      <= oob_d;
      out_node_q <= out_node_d;
      out_par_q  <= out_par_d;
      out_root_q <= out_root_d;
    end
  end

  etp_ram #(.WIDTH(PAR_W), .DEPTH(DEPTH)) u_tree_parent (
    .clk_i   (clk_i),
    .we_i    (tp_we),
    .waddr_i (tp_waddr),
    .wdata_i (tp_wdata),
    .re_i    (tp_re),
    .raddr_i (tp_raddr),
    .rdata_o (tp_rdata)
  );

  etp_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_set_link (
    .clk_i   (clk_i),
    .we_i    (sl_we),
    .waddr_i (sl_waddr),
    .wdata_i (sl_wdata),
    .re_i    (sl_re),
    .raddr_i (sl_raddr),
    .rdata_o (sl_rdata)
  );

  etp_ram #(.WIDTH(SIZE_W), .DEPTH(DEPTH)) u_set_size (
    .clk_i   (clk_i),
    .we_i    (ss_we),
    .waddr_i (ss_waddr),
    .wdata_i (ss_wdata),
    .re_i    (ss_re),
    .raddr_i (ss_raddr),
    .rdata_o (ss_rdata)
  );

  etp_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_set_root (
    .clk_i   (clk_i),
    .we_i    (sr_we),
    .waddr_i (sr_waddr),
    .wdata_i (sr_wdata),
    .re_i    (sr_re),
    .raddr_i (sr_raddr),
    .rdata_o (sr_rdata)
  );

endmodule

FILE: rtl/etp_checker.sv
// Port-level checks for elimination_tree_parents, attached by bind.
// Depends on etp_pkg and the top level's interface ports.
module etp_checker import etp_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input idx_t node_i,
  input par_t parent_node_i,
  input logic is_root_i,
  input logic cfg_valid_i,
  input logic cfg_ready_i,
  input par_t cfg_row_count_i
);

  par_t row_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= ROW_COUNT_RESET;
    end else if (cfg_valid_i && cfg_ready_i) begin
      row_count_q <= cfg_row_count_i;
    end
  end

  // every accepted item makes the block busy in the cycle after it
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready stayed high after a transfer");

  // a new result only appears at the end of a busy period
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without a preceding read item");

  a_root_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (is_root_i == (parent_node_i == row_count_q)))
    else $error("is_root disagrees with parent_node and the row count");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(node_i) && $stable(parent_node_i) && $stable(is_root_i))
    else $error("stalled result changed");

endmodule

bind elimination_tree_parents etp_checker u_etp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .node_i          (out_o.node),
  .parent_node_i   (out_o.parent_node),
  .is_root_i       (out_o.is_root),
  .cfg_valid_i     (cfg_i.valid),
  .cfg_ready_i     (cfg_i.ready),
  .cfg_row_count_i (cfg_i.row_count)
);

FILE: tb/elimination_tree_parents_checker.sv
// Scoreboard for the elimination tree parent builder: watches the three
// channels, tracks the forest and union-find sets, and checks each read result.
// Depends on etp_pkg and the channel interfaces in etp_if.
module elimination_tree_parents_checker import etp_pkg::*; #(
  parameter int unsigned MAX_ROWS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  etp_in_if           in_i,
  etp_out_if          out_i,
  etp_cfg_if          cfg_i,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned reads_o,
  output int unsigned links_o
);

  typedef struct packed {
    idx_t node;
    par_t parent_node;
    logic is_root;
  } parent_read_t;

  par_t        parent_tbl [MAX_ROWS];
  int unsigned link_tbl   [MAX_ROWS];
  size_t       size_tbl   [MAX_ROWS];
  int unsigned root_tbl   [MAX_ROWS];
  int unsigned row_cur, row_set;
  bit          row_live;
  par_t        rows_cfg;

  parent_read_t reads_due [$];
  int unsigned  err_cnt, read_cnt, link_cnt;

  function automatic int unsigned bound(int unsigned x);
    return (x < MAX_ROWS) ? x : 0;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    err_cnt++;
  endtask

  // Find the set representative, then point every node on the path at it.
  function automatic int unsigned find_rep(int unsigned x);
    int unsigned r, nxt, n;
    r = bound(x);
    for (n = 0; n < MAX_ROWS && bound(link_tbl[r]) != r; n++)
      r = bound(link_tbl[r]);
    x = bound(x);
    for (n = 0; n < MAX_ROWS && x != r; n++) begin
      nxt = bound(link_tbl[x]);
      link_tbl[x] = r;
      x = nxt;
    end
    return r;
  endfunction

  // Union by size; on a tie the first set stays on top.
  function automatic int unsigned merge_sets(int unsigned a, int unsigned b);
    int unsigned big, lesser, t, sum;
    big = bound(a);
    lesser = bound(b);
    if (big == lesser) return big;
    if (size_tbl[big] < size_tbl[lesser]) begin
      t = big;
      big = lesser;
      lesser = t;
    end
    link_tbl[lesser] = big;
    sum = size_tbl[big] + size_tbl[lesser];
    size_tbl[big] = (sum > SIZE_MAX) ? SIZE_MAX : size_t'(sum);
    return big;
  endfunction

  function automatic void row_start(int unsigned row);
    if (row < rows_cfg && row < MAX_ROWS) begin
      parent_tbl[row] = rows_cfg;
      link_tbl[row]   = row;
      size_tbl[row]   = 1;
      root_tbl[row]   = row;
      row_cur  = row;
      row_set  = row;
      row_live = 1'b1;
    end
  endfunction

  function automatic void column_entry(int unsigned col);
    int unsigned rep, root;
    if (!row_live || col >= row_cur) return;
    rep  = find_rep(col);
    root = bound(root_tbl[rep]);
    if (parent_tbl[root] == rows_cfg && root != row_cur) begin
      parent_tbl[root] = par_t'(row_cur);
      row_set = merge_sets(row_set, rep);
      root_tbl[row_set] = row_cur;
      link_cnt++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    parent_read_t got, want;
    par_t p;
    if (!rst_ni) begin
      row_cur  = 0;
      row_set  = 0;
      row_live = 1'b0;
      rows_cfg = ROW_COUNT_RESET;
      reads_due.delete();
      err_cnt  = 0;
      read_cnt = 0;
      link_cnt = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) rows_cfg = cfg_i.row_count;
      if (in_i.valid && in_i.ready) begin
        case (in_i.kind)
          KIND_START: row_start(in_i.index);
          KIND_COL:   column_entry(in_i.index);
          KIND_READ: begin
            p = (in_i.index < MAX_ROWS) ? parent_tbl[in_i.index] : rows_cfg;
            reads_due.push_back('{node: in_i.index, parent_node: p,
                                  is_root: (p == rows_cfg)});
          end
          default: ;
        endcase
      end
      if (out_i.valid && out_i.ready) begin
        got = '{node: out_i.node, parent_node: out_i.parent_node, is_root: out_i.is_root};
        if (reads_due.size() == 0) begin
          report_mismatch($sformatf("result for node %0d with no read pending", got.node));
        end else begin
          want = reads_due.pop_front();
          read_cnt++;
          if (got.node !== want.node)
            report_mismatch($sformatf("node %0d, expected %0d", got.node, want.node));
          if (got.parent_node !== want.parent_node)
            report_mismatch($sformatf("node %0d parent %0d, expected %0d",
                                      want.node, got.parent_node, want.parent_node));
          if (got.is_root !== want.is_root)
            report_mismatch($sformatf("node %0d root flag %0b, expected %0b",
                                      want.node, got.is_root, want.is_root));
        end
      end
    end
    errors_o  <= err_cnt;
    pending_o <= reads_due.size();
    reads_o   <= read_cnt;
    links_o   <= link_cnt;
  end

endmodule

FILE: tb/elimination_tree_parents_tb.sv
// Top of the elimination tree parent builder testbench: clock, reset, stimulus
// and verdict. Depends on etp_pkg, etp_if, the block and the checker module.
module elimination_tree_parents_tb;
  import etp_pkg::*;

  localparam int unsigned MAX_ROWS      = 1024;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned RANDOM_ITEMS  = 1650;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam kind_t       KIND_SPARE    = 2'd3;

  logic clk_i;
  logic rst_ni;

  etp_in_if  in_ch ();
  etp_out_if out_ch ();
  etp_cfg_if cfg_ch ();

  int unsigned errors, pending, reads_seen, links_seen;
  int unsigned rows_now, cur_row, cycle_cnt;
  int unsigned item_cnt, rand_items, col_items, phase_cnt;
  bit          row_live, counting, calm;
  bit          started [MAX_ROWS];

  elimination_tree_parents #(.MAX_ROWS(MAX_ROWS)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  elimination_tree_parents_checker #(.MAX_ROWS(MAX_ROWS)) u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_ch),
    .out_i     (out_ch),
    .cfg_i     (cfg_ch),
    .errors_o  (errors),
    .pending_o (pending),
    .reads_o   (reads_seen),
    .links_o   (links_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reads outstanding", cycle_cnt, pending);
      $display("elimination_tree_parents_tb: done, errors");
      $finish;
    end
  end

  // Result side: random back-pressure outside calm phases, plus one long
  // hold-off at the start of every sixth phase.
  initial begin
    int unsigned held_phase;
    held_phase = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (phase_cnt % 6 == 2 && held_phase != phase_cnt) begin
        held_phase = phase_cnt;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 27);
      end
    end
  end

  task automatic send_item(input kind_t k, input int unsigned idx);
    if (!calm && $urandom_range(99) < 27) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= k;
    in_ch.index <= idx_t'(idx);
    do @(posedge clk_i); while (!in_ch.ready);
    // mirror what the block accepted so later columns and reads stay legal
    if (k == KIND_START && idx < rows_now) begin
      started[idx] = 1'b1;
      cur_row  = idx;
      row_live = 1'b1;
    end
    if (k == KIND_COL) col_items++;
    item_cnt++;
    if (counting) rand_items++;
  endtask

  // Drain: the block works one item at a time, so once the last read is back
  // only a short settle remains.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_rows(input int unsigned v);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.row_count <= par_t'(v);
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    rows_now = v;
  endtask

  task automatic send_noise(input int unsigned base);
    int unsigned j;
    case ($urandom_range(0, 3))
      0: send_item(KIND_SPARE, $urandom_range(0, MAX_ROWS - 1));
      1: send_item(KIND_COL, $urandom_range(cur_row, MAX_ROWS - 1));
      2: begin
        if (rows_now < MAX_ROWS)
          send_item(KIND_START, $urandom_range(rows_now, MAX_ROWS - 1));
        else if (cur_row > base)
          send_item(KIND_START, $urandom_range(base, cur_row - 1));  // restart
      end
      default: begin
        j = $urandom_range(0, MAX_ROWS - 1);
        if (started[j]) send_item(KIND_READ, j);
        else send_item(KIND_SPARE, j);
      end
    endcase
  endtask

  // One well-formed pattern: ascending rows from a random base, each with a
  // few column entries below the diagonal, some reads and a little noise.
  task automatic run_phase(input int unsigned setting);
    int unsigned n, base, r, j, k, span;
    write_rows(setting);
    n = $urandom_range(8, 70);
    if (n > setting) n = setting;
    base = $urandom_range(0, setting - n);
    for (r = base; r < base + n; r++) begin
      if ($urandom_range(99) < 8) send_noise(base);
      send_item(KIND_START, r);
      k = $urandom_range(0, 5);
      repeat (k) begin
        if (row_live && cur_row > base) begin
          span = cur_row - base;
          if ($urandom_range(1))
            j = cur_row - 1 - $urandom_range(0, (span > 4) ? 3 : span - 1);
          else
            j = $urandom_range(base, cur_row - 1);
          send_item(KIND_COL, j);
        end
      end
      if ($urandom_range(99) < 25) send_item(KIND_READ, $urandom_range(base, r));
    end
    send_item(KIND_READ, base);
    wait_idle();
  endtask

  initial begin
    int unsigned setting;
    rst_ni           <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.kind       <= KIND_START;
    in_ch.index      <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.row_count <= ROW_COUNT_RESET;
    rows_now = ROW_COUNT_RESET;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_rows(MAX_ROWS);
    send_item(KIND_COL, 5);            // no row open yet
    send_item(KIND_SPARE, MAX_ROWS - 1);
    send_item(KIND_START, 0);
    send_item(KIND_READ, 0);
    send_item(KIND_START, 1);
    send_item(KIND_COL, 0);            // links 0 under 1
    send_item(KIND_COL, 0);            // root already this row
    send_item(KIND_COL, 1);            // diagonal
    send_item(KIND_COL, MAX_ROWS - 1); // above the diagonal
    send_item(KIND_START, 2);
    send_item(KIND_COL, 0);            // subtree root 1 goes under 2
    send_item(KIND_START, MAX_ROWS - 1);
    send_item(KIND_COL, 2);
    send_item(KIND_COL, 0);
    send_item(KIND_READ, 0);
    send_item(KIND_READ, 1);
    send_item(KIND_READ, 2);
    send_item(KIND_READ, MAX_ROWS - 1);
    wait_idle();

    // Smallest dimension: stored parents keep the old unattached code.
    write_rows(1);
    send_item(KIND_START, 1);          // out of range, row stays open
    send_item(KIND_START, 0);
    send_item(KIND_COL, 0);
    send_item(KIND_READ, 0);
    send_item(KIND_READ, MAX_ROWS - 1);
    send_item(KIND_READ, 2);
    wait_idle();

    counting = 1'b1;
    while (rand_items < RANDOM_ITEMS) begin
      case (phase_cnt % 6)
        0:       setting = MAX_ROWS;
        1:       setting = 2;
        2:       setting = $urandom_range(3, MAX_ROWS - 1);
        3:       setting = MAX_ROWS;
        4:       setting = 1;
        default: setting = $urandom_range(64, MAX_ROWS - 1);
      endcase
      calm = (phase_cnt % 6 == 3);
      run_phase(setting);
      phase_cnt++;
    end
    calm = 1'b0;

    $display("ran %0d items (%0d random, %0d column entries) over %0d register settings",
             item_cnt, rand_items, col_items, phase_cnt + 2);
    $display("checked %0d parent reads; %0d subtree links made", reads_seen, links_seen);
    if (errors == 0 && pending == 0) begin
      $display("elimination_tree_parents_tb: done, clean");
    end else begin
      $display("%0d mismatches, %0d reads outstanding", errors, pending);
      $display("elimination_tree_parents_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: elimination_tree_parents.f
rtl/etp_pkg.sv
rtl/etp_if.sv
rtl/etp_ram.sv
rtl/elimination_tree_parents.sv
rtl/etp_checker.sv
tb/elimination_tree_parents_checker.sv
tb/elimination_tree_parents_tb.sv
